/* hw/rtl/mpq_pkg.sv */
// Shared types and constants for the min priority queue.
// Used by mpq_engine, mpq_out_stage and min_priority_queue; no dependencies.
package mpq_pkg;

  localparam int VALUE_W         = 32;
  localparam int OCC_W           = 5;
  localparam int STATUS_W        = 2;
  localparam int IN_TDATA_W      = 32;
  localparam int OUT_TDATA_W     = 40;
  localparam int DEF_QUEUE_DEPTH = 16;

  // Command carried on the input tuser
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // Result status carried on the output tuser
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // One result word between the engine and the output stage
  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    status_t                   status;
    logic [OCC_W-1:0]          occupancy;
  } res_t;

endpackage

/* hw/rtl/mpq_engine.sv */
// Queue engine: value memory, fill count and the minimum scan sequencer.
// Depends on mpq_pkg; feeds mpq_out_stage.
module mpq_engine #(
  parameter int QUEUE_DEPTH = mpq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mpq_pkg::cmd_t                       in_cmd,
  input  logic signed [mpq_pkg::VALUE_W-1:0]  in_value,
  input  logic                                stage_ready,
  output logic                                res_valid,
  output mpq_pkg::res_t                       res
);
  import mpq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIX
  } state_t;

  state_t                    state_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          iss_r;
  logic                      dvld_r;
  logic [IDX_W-1:0]          didx_r;
  logic                      first_r;
  logic signed [VALUE_W-1:0] best_val_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic signed [VALUE_W-1:0] last_val_r;

  logic signed [VALUE_W-1:0] mem_r [QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;

  logic             accept;
  logic             is_empty;
  logic             is_full;
  logic             issue;
  logic [IDX_W-1:0] last_idx;
  logic             cand_take;
  logic             scan_end;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;

  // Handshake and queue condition
  assign in_ready = (state_r == ST_IDLE) && stage_ready;
  assign accept   = in_valid && in_ready;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(QUEUE_DEPTH));

  // Scan: issue one read per cycle, compare the word that comes back
  assign issue     = (state_r == ST_SCAN) && (iss_r < count_r);
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign cand_take = dvld_r && (first_r || (rd_data_r < best_val_r));
  assign scan_end  = dvld_r && (didx_r == last_idx);

  // Memory write: append on insert, move the tail into the hole on remove
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[IDX_W-1:0];
    mem_wdata = in_value;
    unique case (state_r)
      ST_IDLE: begin
        mem_we = accept && (in_cmd == CMD_INSERT) && !is_full;
      end
      ST_FIX: begin
        mem_we    = stage_ready;
        mem_waddr = best_idx_r;
        mem_wdata = last_val_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[iss_r[IDX_W-1:0]];
  end

  // Result word toward the output stage
  always_comb begin
    res_valid         = 1'b0;
    res.removed_value = '0;
    res.status        = STATUS_OK;
    res.occupancy     = OCC_W'(count_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_cmd == CMD_INSERT) begin
          res_valid = accept;
          if (is_full) begin
            res.status = STATUS_FULL;
          end else begin
            res.occupancy = OCC_W'(count_r + CNT_W'(1));
          end
        end else begin
          res_valid  = accept && is_empty;
          res.status = STATUS_EMPTY;
        end
      end
      ST_FIX: begin
        res_valid         = stage_ready;
        res.removed_value = best_val_r;
        res.occupancy     = OCC_W'(count_r - CNT_W'(1));
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      dvld_r  <= 1'b0;
      first_r <= 1'b1;
      iss_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_cmd == CMD_INSERT) begin
              if (!is_full) begin
                count_r <= count_r + CNT_W'(1);
              end
            end else if (!is_empty) begin
              state_r <= ST_SCAN;
              iss_r   <= '0;
              dvld_r  <= 1'b0;
              first_r <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            iss_r <= iss_r + CNT_W'(1);
          end
          dvld_r <= issue;
          didx_r <= iss_r[IDX_W-1:0];
          // keep the earliest of equal minima: strict compare
          if (cand_take) begin
            best_val_r <= rd_data_r;
            best_idx_r <= didx_r;
            first_r    <= 1'b0;
          end
          if (scan_end) begin
            last_val_r <= rd_data_r;
            state_r    <= ST_FIX;
          end
        end
        ST_FIX: begin
          if (stage_ready) begin
            count_r <= count_r - CNT_W'(1);
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/mpq_out_stage.sv */
// Output register: holds one result word until the downstream side takes it.
// Depends on mpq_pkg; driven by mpq_engine.
module mpq_out_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                res_valid,
  input  mpq_pkg::res_t                       res,
  output logic                                stage_ready,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mpq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [mpq_pkg::STATUS_W-1:0]        out_tuser
);
  import mpq_pkg::*;

  logic vld_r;
  res_t res_r;

  // Free when empty or being drained this cycle
  assign stage_ready = !vld_r || out_tready;

  // Load a new word, or drop the one just taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_valid) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - VALUE_W - OCC_W){1'b0}},
                       res_r.occupancy, res_r.removed_value};
  assign out_tuser  = res_r.status;

endmodule

/* hw/rtl/min_priority_queue.sv */
// Min priority queue top level: engine plus output register.
// Depends on mpq_pkg, mpq_engine and mpq_out_stage.
//
//   channel  | direction | tdata (low bit first)                 | tuser
//   ---------+-----------+---------------------------------------+----------------
//   in_      | slave     | value[31:0]                           | cmd (0 ins, 1 rm)
//   out_     | master    | removed_value[31:0], occupancy[36:32] | status[1:0]
//
// Insert, and any command that fails, reaches the output register in the
// cycle after accept. Remove of n stored values makes one read per cycle
// over the single memory read port, takes each word from a registered read,
// then writes the tail back into the freed slot. One word is in work at a time.
// Reset empties the queue at once; no clearing pass runs over the memory.
// A stalled output holds the result; input is accepted again once the output
// register is free or being drained.
module min_priority_queue #(
  parameter int QUEUE_DEPTH = mpq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mpq_pkg::IN_TDATA_W-1:0]   in_tdata,   // value[31:0]
  input  logic                             in_tuser,   // cmd[0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mpq_pkg::OUT_TDATA_W-1:0]  out_tdata,  // removed_value[31:0], occupancy[36:32]
  output logic [mpq_pkg::STATUS_W-1:0]     out_tuser   // status[1:0]
);
  import mpq_pkg::*;

  logic stage_ready;
  logic res_valid;
  res_t res;
  cmd_t in_cmd;

  assign in_cmd = cmd_t'(in_tuser);

  mpq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_cmd),
    .in_value    ($signed(in_tdata[VALUE_W-1:0])),
    .stage_ready (stage_ready),
    .res_valid   (res_valid),
    .res         (res)
  );

  mpq_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res         (res),
    .stage_ready (stage_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
